FILE: sv/lbps_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lbps_pkg: shared types, constants and pattern tables
// Mode codes, the sequencer state record and the pause lookup for each step.
// ============================================================================
package lbps_pkg;

    // Counter and register widths
    localparam int PAUSE_BITS = 20;
    localparam int CFG_BITS   = 20;
    localparam int STEP_BITS  = 4;
    localparam int WIDE_BITS  = (PAUSE_BITS > CFG_BITS) ? PAUSE_BITS : CFG_BITS;

    // Register reset values
    localparam logic [CFG_BITS-1:0] SHORT_RESET = CFG_BITS'(300000);
    localparam logic [CFG_BITS-1:0] LONG_RESET  = CFG_BITS'(1000000);

    // Pattern lengths in toggles
    localparam logic [STEP_BITS-1:0] STARTUP_LEN = STEP_BITS'(4);
    localparam logic [STEP_BITS-1:0] MOUNT_LEN   = STEP_BITS'(10);
    localparam logic [STEP_BITS-1:0] UNMOUNT_LEN = STEP_BITS'(12);

    // Unmount steps that use the long pause
    localparam logic [STEP_BITS-1:0] UNMOUNT_LONG_A = STEP_BITS'(3);
    localparam logic [STEP_BITS-1:0] UNMOUNT_LONG_B = STEP_BITS'(8);

    // Configuration register indexes
    localparam logic REG_SHORT_PAUSE = 1'b0;
    localparam logic REG_LONG_PAUSE  = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STARTUP = 2'd1,
        MODE_MOUNT   = 2'd2,
        MODE_UNMOUNT = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                 mode_now;
        t_mode                 mode_queued;
        logic [STEP_BITS-1:0]  toggles_done;
        logic [PAUSE_BITS-1:0] pause_left;
        logic                  led_on;
    } t_seq_state;

    // Number of toggles in a pattern
    function automatic logic [STEP_BITS-1:0] pattern_len(t_mode mode);
        logic [STEP_BITS-1:0] len;
        case (mode)
            MODE_STARTUP: len = STARTUP_LEN;
            MODE_MOUNT:   len = MOUNT_LEN;
            MODE_UNMOUNT: len = UNMOUNT_LEN;
            default:      len = '0;
        endcase
        return len;
    endfunction

    // Clamp a register value to the pause counter range
    function automatic logic [PAUSE_BITS-1:0] sat_pause(logic [CFG_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        logic [WIDE_BITS-1:0] lim;
        w   = WIDE_BITS'(v);
        lim = WIDE_BITS'({PAUSE_BITS{1'b1}});
        if (w > lim) begin
            w = lim;
        end
        return w[PAUSE_BITS-1:0];
    endfunction

    // Pause loaded for a step; past the end, reuse the final step's pause
    function automatic logic [PAUSE_BITS-1:0] pause_for(
        t_mode                mode,
        logic [STEP_BITS-1:0] step,
        logic [CFG_BITS-1:0]  short_ticks,
        logic [CFG_BITS-1:0]  long_ticks
    );
        logic [STEP_BITS-1:0] len;
        logic [STEP_BITS-1:0] s;
        logic                 is_long;
        len     = pattern_len(mode);
        s       = (step >= len) ? (len - STEP_BITS'(1)) : step;
        is_long = 1'b0;
        case (mode)
            MODE_MOUNT:   is_long = 1'b1;
            MODE_UNMOUNT: is_long = (s == UNMOUNT_LONG_A) || (s == UNMOUNT_LONG_B);
            default:      is_long = 1'b0;
        endcase
        if (len == '0) begin
            return '0;
        end
        return sat_pause(is_long ? long_ticks : short_ticks);
    endfunction

endpackage

FILE: sv/lbps_step.sv
`timescale 1ns / 1ps
// ============================================================================
// lbps_step: next-state logic of the blink sequencer
// Applies one request (tick or mode request) to the current sequencer state.
// ============================================================================
module lbps_step (
    input  lbps_pkg::t_seq_state               i_state,
    input  logic                               i_cmd,
    input  lbps_pkg::t_mode                    i_req_mode,
    input  logic [lbps_pkg::CFG_BITS-1:0]      i_short_ticks,
    input  logic [lbps_pkg::CFG_BITS-1:0]      i_long_ticks,
    output lbps_pkg::t_seq_state               o_state
);
    import lbps_pkg::*;

    logic [STEP_BITS-1:0] cur_len;
    logic [STEP_BITS-1:0] q_len;
    logic [STEP_BITS-1:0] next_step;

    assign cur_len   = pattern_len(i_state.mode_now);
    assign q_len     = pattern_len(i_state.mode_queued);
    assign next_step = i_state.toggles_done + STEP_BITS'(1);

    always_comb begin
        o_state = i_state;
        if (i_cmd) begin
            // Start a pattern when idle, otherwise overwrite the queue
            if (i_state.mode_now == MODE_IDLE) begin
                o_state.mode_now     = i_req_mode;
                o_state.mode_queued  = MODE_IDLE;
                o_state.led_on       = 1'b1;
                o_state.toggles_done = '0;
                o_state.pause_left   = pause_for(i_req_mode, '0, i_short_ticks,
                                                 i_long_ticks);
            end else begin
                o_state.mode_queued = i_req_mode;
            end
        end else if (i_state.mode_now != MODE_IDLE) begin
            if (i_state.pause_left <= PAUSE_BITS'(1)) begin
                if (i_state.toggles_done < cur_len) begin
                    // Toggle and load the next step's pause
                    o_state.toggles_done = next_step;
                    o_state.led_on       = ~i_state.led_on;
                    o_state.pause_left   = pause_for(i_state.mode_now, next_step,
                                                     i_short_ticks, i_long_ticks);
                end else if (q_len != '0) begin
                    // Chain the queued pattern with an immediate toggle
                    o_state.mode_now     = i_state.mode_queued;
                    o_state.mode_queued  = MODE_IDLE;
                    o_state.toggles_done = STEP_BITS'(1);
                    o_state.led_on       = ~i_state.led_on;
                    o_state.pause_left   = pause_for(i_state.mode_queued,
                                                     STEP_BITS'(1), i_short_ticks,
                                                     i_long_ticks);
                end else begin
                    // Nothing queued: drop to idle with the LED off
                    o_state.mode_now     = MODE_IDLE;
                    o_state.mode_queued  = MODE_IDLE;
                    o_state.toggles_done = '0;
                    o_state.pause_left   = '0;
                    o_state.led_on       = 1'b0;
                end
            end else begin
                o_state.pause_left = i_state.pause_left - PAUSE_BITS'(1);
            end
        end
    end

endmodule

FILE: sv/led_blink_pattern_sequencer.sv
`timescale 1ns / 1ps
// ============================================================================
// led_blink_pattern_sequencer: LED blink pattern player
// Plays the startup, mount and unmount blink patterns from tick and mode
// requests, with one queued mode chained in when a pattern ends.
// ============================================================================
// Channel   Direction  Handshake                   Payload
// in        request    i_in_valid / o_in_ready     i_cmd, i_requested_mode
// out       result     o_out_valid / i_out_ready   o_led_level, o_active_mode,
//                                                  o_queued_mode, o_step_index
// cfg       write      i_cfg_we                    i_cfg_index, i_cfg_wdata
//
// The state registers and the result register both load the new state at the
// edge that accepts a request.
// A request is taken every cycle while the result register is empty or is
// being drained in the same cycle; a stalled result holds off new requests.
// Synchronous reset clears the state and loads the default pause lengths.
// ============================================================================
module led_blink_pattern_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [1:0]                    i_requested_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_led_level,
    output logic [1:0]                    o_active_mode,
    output logic [1:0]                    o_queued_mode,
    output logic [lbps_pkg::STEP_BITS-1:0] o_step_index,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [lbps_pkg::CFG_BITS-1:0] i_cfg_wdata
);
    import lbps_pkg::*;

    t_seq_state           r_state;
    t_seq_state           n_state;
    logic [CFG_BITS-1:0]  r_short_ticks;
    logic [CFG_BITS-1:0]  r_long_ticks;
    logic                 r_out_valid;
    logic                 r_led;
    t_mode                r_active;
    t_mode                r_queued;
    logic [STEP_BITS-1:0] r_step;
    logic                 accept;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;

    lbps_step u_step (
        .i_state       (r_state),
        .i_cmd         (i_cmd),
        .i_req_mode    (t_mode'(i_requested_mode)),
        .i_short_ticks (r_short_ticks),
        .i_long_ticks  (r_long_ticks),
        .o_state       (n_state)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= SHORT_RESET;
            r_long_ticks  <= LONG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SHORT_PAUSE: r_short_ticks <= i_cfg_wdata;
                REG_LONG_PAUSE:  r_long_ticks  <= i_cfg_wdata;
                default:         r_short_ticks <= r_short_ticks;
            endcase
        end
    end

    // Advance the sequencer state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode_now     <= MODE_IDLE;
            r_state.mode_queued  <= MODE_IDLE;
            r_state.toggles_done <= '0;
            r_state.pause_left   <= '0;
            r_state.led_on       <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_led    <= n_state.led_on;
            r_active <= n_state.mode_now;
            r_queued <= n_state.mode_queued;
            r_step   <= n_state.toggles_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_level   = r_led;
    assign o_active_mode = r_active;
    assign o_queued_mode = r_queued;
    assign o_step_index  = r_step;

    // Toggle count never passes the pattern length
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.toggles_done <= pattern_len(r_state.mode_now))
        else $error("toggle count beyond pattern length");

    // Idle mode carries no pause and no queued mode
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode_now == MODE_IDLE) |->
            (r_state.pause_left == '0) && (r_state.mode_queued == MODE_IDLE))
        else $error("idle state holds a pause or a queued mode");

    // Every accepted request yields a pending result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no result");

    // Result fields mirror the state after the last request
    a_result_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_step == r_state.toggles_done) && (r_led == r_state.led_on))
        else $error("result register out of step with state");

endmodule

FILE: dv/lbps_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// lbps_checker: result predictor and scoreboard for the blink sequencer
// Watches the request, result and register write ports, keeps its own copy of
// the pattern state and pause registers, and compares every result in order.
// ============================================================================
package lbps_tb_pkg;

    // Request kinds carried on i_cmd
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

endpackage

module lbps_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_cmd,
    input  logic [1:0]                    i_requested_mode,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_led_level,
    input  logic [1:0]                    i_active_mode,
    input  logic [1:0]                    i_queued_mode,
    input  logic [lbps_pkg::STEP_BITS-1:0] i_step_index,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [lbps_pkg::CFG_BITS-1:0] i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import lbps_pkg::*;
    import lbps_tb_pkg::*;

    typedef struct packed {
        logic                 led;
        t_mode                active;
        t_mode                queued;
        logic [STEP_BITS-1:0] steps;
    } t_blink_view;

    t_seq_state          seq;
    logic [CFG_BITS-1:0] short_ticks;
    logic [CFG_BITS-1:0] long_ticks;
    t_blink_view         expected_views[$];
    int                  fail_total;

    // Toggle count of each pattern
    function automatic logic [STEP_BITS-1:0] toggles_in(t_mode m);
        case (m)
            MODE_STARTUP: return STARTUP_LEN;
            MODE_MOUNT:   return MOUNT_LEN;
            MODE_UNMOUNT: return UNMOUNT_LEN;
            default:      return '0;
        endcase
    endfunction

    // Pause for a step; steps past the end hold the final pause
    function automatic logic [PAUSE_BITS-1:0] pause_at(t_mode m, logic [STEP_BITS-1:0] step);
        logic [STEP_BITS-1:0] n;
        logic [STEP_BITS-1:0] s;
        logic [CFG_BITS-1:0]  v;
        logic                 is_long;
        n = toggles_in(m);
        if (n == '0) begin
            return '0;
        end
        s = (step >= n) ? n - 1'b1 : step;
        is_long = (m == MODE_MOUNT) ||
                  ((m == MODE_UNMOUNT) && ((s == UNMOUNT_LONG_A) || (s == UNMOUNT_LONG_B)));
        v = is_long ? long_ticks : short_ticks;
        // Saturate a register value that does not fit the counter
        if ((CFG_BITS > PAUSE_BITS) && ((v >> PAUSE_BITS) != '0)) begin
            return '1;
        end
        return PAUSE_BITS'(v);
    endfunction

    // Make one toggle if the pattern has steps left
    function automatic bit take_toggle();
        logic [STEP_BITS-1:0] n;
        n = toggles_in(seq.mode_now);
        if ((n != '0) && (seq.toggles_done < n)) begin
            seq.toggles_done = seq.toggles_done + 1'b1;
            seq.led_on       = ~seq.led_on;
            seq.pause_left   = pause_at(seq.mode_now, seq.toggles_done);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the pattern state by one request
    function automatic void blink_apply(logic cmd, t_mode req);
        if (cmd == CMD_REQUEST) begin
            if (seq.mode_now == MODE_IDLE) begin
                seq.mode_now     = req;
                seq.mode_queued  = MODE_IDLE;
                seq.led_on       = 1'b1;
                seq.toggles_done = '0;
                seq.pause_left   = pause_at(req, '0);
            end else begin
                seq.mode_queued = req;
            end
        end else if (seq.mode_now != MODE_IDLE) begin
            if (seq.pause_left <= 1) begin
                // Pause over: toggle if steps remain, else chain in the queued mode or go dark
                if (!take_toggle()) begin
                    seq.toggles_done = '0;
                    seq.mode_now     = seq.mode_queued;
                    seq.mode_queued  = MODE_IDLE;
                    if (!take_toggle()) begin
                        seq.mode_now   = MODE_IDLE;
                        seq.pause_left = '0;
                        seq.led_on     = 1'b0;
                    end
                end
            end else begin
                seq.pause_left = seq.pause_left - 1'b1;
            end
        end
    endfunction

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_total++;
        end
    endtask

    // Compare drained results, then predict the newly accepted request
    always @(posedge i_clk) begin
        t_blink_view want;
        if (!i_rst_n) begin
            seq.mode_now     = MODE_IDLE;
            seq.mode_queued  = MODE_IDLE;
            seq.toggles_done = '0;
            seq.pause_left   = '0;
            seq.led_on       = 1'b0;
            short_ticks      = SHORT_RESET;
            long_ticks       = LONG_RESET;
            expected_views.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_views.size() == 0) begin
                    $display({"%0t ns: result with no request pending, expected none, ",
                              "actual %0d/%0d/%0d/%0d"},
                             $time, i_led_level, i_active_mode, i_queued_mode, i_step_index);
                    fail_total++;
                end else begin
                    want = expected_views.pop_front();
                    check_field("led_level", 4'(want.led), 4'(i_led_level));
                    check_field("active_mode", 4'(want.active), 4'(i_active_mode));
                    check_field("queued_mode", 4'(want.queued), 4'(i_queued_mode));
                    check_field("step_index", 4'(want.steps), 4'(i_step_index));
                end
            end
            if (i_in_valid && i_in_ready) begin
                blink_apply(i_cmd, t_mode'(i_requested_mode));
                want.led    = seq.led_on;
                want.active = seq.mode_now;
                want.queued = seq.mode_queued;
                want.steps  = seq.toggles_done;
                expected_views.push_back(want);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SHORT_PAUSE) begin
                    short_ticks = i_cfg_wdata;
                end else begin
                    long_ticks = i_cfg_wdata;
                end
            end
        end
        o_pending    = expected_views.size();
        o_fail_count = fail_total;
    end

endmodule

FILE: dv/tb_led_blink_pattern_sequencer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_led_blink_pattern_sequencer: regression bench for the blink sequencer
// Drives tick and mode requests in random bursts under several pause settings
// while the result side stalls on its own pattern; the checker scores results.
// ============================================================================
module tb_led_blink_pattern_sequencer;
    import lbps_pkg::*;
    import lbps_tb_pkg::*;

    localparam int     HOLD_CYCLES   = 240;
    localparam int     HOLD_AFTER    = 600;
    localparam int     PHASE_ITEMS   = 112;
    localparam int     RANDOM_PHASES = 6;
    localparam longint TIMEOUT_NS    = 4_000_000;
    localparam logic [CFG_BITS-1:0] PAUSE_MAX = {CFG_BITS{1'b1}};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_cmd;
    logic [1:0]           i_requested_mode;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_led_level;
    logic [1:0]           o_active_mode;
    logic [1:0]           o_queued_mode;
    logic [STEP_BITS-1:0] o_step_index;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_BITS-1:0]  i_cfg_wdata;
    int                   fail_count;
    int                   pending;

    led_blink_pattern_sequencer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_requested_mode (i_requested_mode),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_led_level      (o_led_level),
        .o_active_mode    (o_active_mode),
        .o_queued_mode    (o_queued_mode),
        .o_step_index     (o_step_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    lbps_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_requested_mode (i_requested_mode),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_led_level      (o_led_level),
        .i_active_mode    (o_active_mode),
        .i_queued_mode    (o_queued_mode),
        .i_step_index     (o_step_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Offer one request and hold it until the edge that accepts it
    task automatic push_request(input logic cmd, input t_mode mode);
        logic took;
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_requested_mode <= mode;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = (o_in_ready === 1'b1);
            @(posedge i_clk);
        end
    endtask

    task automatic run_ticks(input int n);
        repeat (n) push_request(CMD_TICK, t_mode'($urandom_range(0, 3)));
    endtask

    // Drop valid and wait until every result has drained
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_pauses(input logic [CFG_BITS-1:0] short_v,
                                input logic [CFG_BITS-1:0] long_v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SHORT_PAUSE;
        i_cfg_wdata <= short_v;
        @(posedge i_clk);
        i_cfg_index <= REG_LONG_PAUSE;
        i_cfg_wdata <= long_v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly ticks with occasional mode requests, in bursts with gaps
    task automatic run_random(input int n);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 24);
            while ((burst > 0) && (sent < n)) begin
                push_request(($urandom_range(0, 9) == 0) ? CMD_REQUEST : CMD_TICK,
                             t_mode'($urandom_range(0, 3)));
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Result side: random stall styles, plus one long hold-off
    initial begin : result_sink
        int  style;
        int  span;
        int  cycles;
        bit  held;
        i_out_ready <= 1'b0;
        cycles = 0;
        held   = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 60);
            repeat (span) begin
                @(posedge i_clk);
                cycles++;
                if (!held && (cycles >= HOLD_AFTER)) begin
                    i_out_ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                    held = 1'b1;
                end else begin
                    case (style)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= 1'($urandom_range(0, 1));
                        2:       i_out_ready <= ($urandom_range(0, 3) != 0);
                        default: i_out_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        int                  ph;
        logic [CFG_BITS-1:0] short_v;
        logic [CFG_BITS-1:0] long_v;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_cmd            <= CMD_TICK;
        i_requested_mode <= MODE_IDLE;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= REG_SHORT_PAUSE;
        i_cfg_wdata      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle behavior: ticks do nothing, an idle request lights the LED
        push_request(CMD_TICK, MODE_UNMOUNT);
        push_request(CMD_REQUEST, MODE_IDLE);
        push_request(CMD_TICK, MODE_MOUNT);
        push_request(CMD_REQUEST, MODE_IDLE);
        drain_block();

        // One-tick pauses: startup, queue overwrite, chained unmount, then dark
        write_pauses(CFG_BITS'(1), CFG_BITS'(1));
        push_request(CMD_REQUEST, MODE_STARTUP);
        run_ticks(2);
        push_request(CMD_REQUEST, MODE_MOUNT);
        push_request(CMD_REQUEST, MODE_UNMOUNT);
        run_ticks(3);
        push_request(CMD_REQUEST, MODE_IDLE);
        run_ticks(12);
        drain_block();

        // Random traffic under several pause settings
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin short_v = CFG_BITS'(1); long_v = CFG_BITS'(1); end
                1: begin short_v = CFG_BITS'(2); long_v = CFG_BITS'(3); end
                2: begin short_v = CFG_BITS'(1); long_v = CFG_BITS'(6); end
                3: begin short_v = CFG_BITS'(5); long_v = CFG_BITS'(1); end
                default: begin
                    short_v = CFG_BITS'($urandom_range(1, 8));
                    long_v  = CFG_BITS'($urandom_range(1, 8));
                end
            endcase
            write_pauses(short_v, long_v);
            run_random(PHASE_ITEMS);
            drain_block();
        end

        // Run any pattern out so the block is back to idle
        write_pauses(CFG_BITS'(1), CFG_BITS'(1));
        run_ticks(40);
        drain_block();

        // Largest long pause loaded at unmount step three
        write_pauses(CFG_BITS'(1), PAUSE_MAX);
        push_request(CMD_REQUEST, MODE_UNMOUNT);
        run_ticks(6);
        push_request(CMD_REQUEST, MODE_MOUNT);
        run_ticks(3);
        drain_block();

        // Largest short pause too, queue overwritten while busy
        write_pauses(PAUSE_MAX, PAUSE_MAX);
        push_request(CMD_REQUEST, MODE_STARTUP);
        run_ticks(4);
        drain_block();

        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("led_blink_pattern_sequencer regression: pass");
        end else begin
            $display("led_blink_pattern_sequencer regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("led_blink_pattern_sequencer regression: fail");
        $finish;
    end

endmodule

FILE: files.f
sv/lbps_pkg.sv
sv/lbps_step.sv
sv/led_blink_pattern_sequencer.sv
dv/lbps_checker.sv
dv/tb_led_blink_pattern_sequencer.sv
